>>> rtl/dpt_pkg.sv
// Shared constants and the constant log2 helper for the dew point block.
`default_nettype none
package dpt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int T_W           = 15;
    localparam int H_W           = 20;
    localparam int DEW_W         = 16;
    localparam int E_W           = 5;
    localparam int LOG_FRAC      = 30;
    localparam int L2_W          = E_W + LOG_FRAC;
    localparam int MANT_W        = LOG_FRAC + 1;

    localparam logic [H_W-1:0]   HUM_FULL = 20'd1000000;
    localparam logic [H_W-1:0]   HUM_MIN  = 20'd1;
    localparam logic [29:0]      LN2_Q30  = 30'd744261118;
    localparam logic [10:0]      K_COEF   = 11'd1727;
    localparam logic [14:0]      B_COEF   = 15'd23770;
    localparam logic [6:0]       PCT_SCALE = 7'd100;
    localparam logic [15:0]      DEW_LOW_MAG = 16'd20000;
    localparam logic [15:0]      DEW_HIGH    = 16'd12500;
    localparam logic signed [DEW_W-1:0] DEW_LOW = -16'sd20000;

    // Same log2 sequence as the hardware, evaluated on constants only.
    function automatic logic [L2_W-1:0] f_log2_q30(input logic [H_W-1:0] x);
        logic [E_W-1:0]      e;
        logic [63:0]         m;
        logic [LOG_FRAC-1:0] frac;
        e = '0;
        for (int i = 0; i < H_W; i++) begin
            if (x[i]) e = E_W'(i);
        end
        m = 64'(x) << (LOG_FRAC - int'(e));
        frac = '0;
        for (int j = 0; j < LOG_FRAC; j++) begin
            m = (m * m) >> LOG_FRAC;
            frac = {frac[LOG_FRAC-2:0], 1'b0};
            if (m[LOG_FRAC+1]) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {e, frac};
    endfunction

endpackage
`default_nettype wire

>>> rtl/dpt_log2.sv
// Pipelined base-2 logarithm in Q30: one normalize stage, then one squaring per stage.
`default_nettype none
module dpt_log2 #(
    parameter int SW = 15
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [dpt_pkg::H_W-1:0]    i_x,
    input  wire logic [SW-1:0]              i_side,
    output logic                            o_valid,
    output logic [dpt_pkg::L2_W-1:0]        o_l2,
    output logic [SW-1:0]                   o_side
);
    localparam int NS = dpt_pkg::LOG_FRAC;
    localparam int MW = dpt_pkg::MANT_W;
    localparam int EW = dpt_pkg::E_W;

    logic                 r_v    [NS+1];
    logic [MW-1:0]        r_m    [NS+1];
    logic [NS-1:0]        r_frac [NS+1];
    logic [EW-1:0]        r_e    [NS+1];
    logic [SW-1:0]        r_side [NS+1];

    logic [EW-1:0] n_e;
    logic [MW-1:0] n_m;

    // Leading one position, then the mantissa brought to [1,2) in Q30.
    always_comb begin
        n_e = '0;
        for (int i = 0; i < dpt_pkg::H_W; i++) begin
            if (i_x[i]) n_e = EW'(i);
        end
        n_m = MW'({{(MW-dpt_pkg::H_W){1'b0}}, i_x} << (EW'(NS) - n_e));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_m[0]    <= n_m;
        r_e[0]    <= n_e;
        r_frac[0] <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= NS; k++) begin : g_sq
        logic [2*MW-1:0] sq;
        logic [MW:0]     top;
        assign sq  = (2*MW)'(r_m[k-1]) * (2*MW)'(r_m[k-1]);
        assign top = sq[NS+MW:NS];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_m[k]    <= top[MW] ? top[MW:1] : top[MW-1:0];
            r_frac[k] <= {r_frac[k-1][NS-2:0], top[MW]};
            r_e[k]    <= r_e[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_v[NS];
    assign o_l2    = {r_e[NS], r_frac[NS]};
    assign o_side  = r_side[NS];
endmodule
`default_nettype wire

>>> rtl/dpt_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module dpt_div #(
    parameter int NW = 42,
    parameter int DW = 22,
    parameter int SW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DW-1:0]  i_den,
    input  wire logic [SW-1:0]  i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_quot,
    output logic [SW-1:0]       o_side
);
    logic           r_v    [NW];
    logic [DW-1:0]  r_rem  [NW];
    logic [NW-1:0]  r_w    [NW];
    logic [DW-1:0]  r_den  [NW];
    logic [SW-1:0]  r_side [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [NW-1:0] p_w;
        logic [SW-1:0] p_side;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_den  = i_den;
            assign p_w    = i_num;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_den  = r_den[k-1];
            assign p_w    = r_w[k-1];
            assign p_side = r_side[k-1];
        end

        // The numerator bits leave at the top while quotient bits enter at the bottom.
        assign trial = {p_rem, p_w[NW-1]};
        assign ge    = trial >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
            r_rem[k]  <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
            r_w[k]    <= {p_w[NW-2:0], ge};
            r_den[k]  <= p_den;
            r_side[k] <= p_side;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quot  = r_w[NW-1];
    assign o_side  = r_side[NW-1];
endmodule
`default_nettype wire

>>> rtl/dew_point_from_temp_humidity.sv
// Top level of the Magnus-Tetens dew point pipeline.
//
// Usage: a sample word (temperature in signed hundredths of a degree C,
// humidity in 0.0001 %RH and a humidity valid flag) is taken at a rising
// edge where start is high and busy is low. Busy drops at the first edge
// after reset is released and then stays low, so one word can be taken in
// every cycle.
// Each word gives exactly one result word: dew point in signed hundredths
// of a degree C and a saturated flag, shown on the output ports for one
// cycle with o_strobe high. The receiver cannot stall; results leave in
// the order their samples came in.
// Pipeline order: the input register, the 31-stage log2, stages D, P, S and
// R, the term1 divider (FRAC_BITS+26 stages), stages A, B and C, the final
// divider (FRAC_BITS+24 stages) and the result register. Each divider
// stage gives one quotient bit.
// Throughput is one word per cycle.
// Reset is synchronous and active low: it empties the pipeline by clearing
// every stage valid bit and holds busy high for its duration.
`default_nettype none
module dew_point_from_temp_humidity #(
    parameter int FRAC_BITS = dpt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [dpt_pkg::T_W-1:0]     i_temperature,
    input  wire logic [dpt_pkg::H_W-1:0]            i_humidity,
    input  wire logic                               i_humidity_valid,
    output logic                                    o_strobe,
    output logic signed [dpt_pkg::DEW_W-1:0]        o_dew,
    output logic                                    o_saturated
);
    localparam int TW   = dpt_pkg::T_W;
    localparam int HW   = dpt_pkg::H_W;
    localparam int LW   = dpt_pkg::L2_W;
    localparam int PLW  = 18;                  // low slice of the ln multiply
    localparam int PHW  = LW - PLW;
    localparam int DLW  = LW + 30;             // ln difference in Q60
    localparam int T2W  = FRAC_BITS + 4;       // |term2| < 14 in Q(FRAC_BITS)
    localparam int TMW  = 25;                  // 1727 * |T|
    localparam int DW1  = 22;                  // 100 * (23770 + T)
    localparam int NW1  = FRAC_BITS + 26;
    localparam int AW   = FRAC_BITS + 8;       // alpha and its divisor
    localparam int PW2  = AW + 15;
    localparam int NW2  = AW + 16;

    localparam logic [LW-1:0] L2_FULL = dpt_pkg::f_log2_q30(dpt_pkg::HUM_FULL);
    localparam longint C_DEN = (longint'(1727) * (longint'(1) << FRAC_BITS) + 50) / 100;
    localparam logic [DLW-1:0] RND_T2 = DLW'(1) << (59 - FRAC_BITS);

    // Stage 0: input register with humidity cleanup.
    logic                 r_busy;
    logic                 accept;
    logic                 r0_v;
    logic signed [TW-1:0] r0_t;
    logic [HW-1:0]        r0_h;
    logic [HW-1:0]        n0_h;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        if (!i_humidity_valid || i_humidity == '0) begin
            n0_h = dpt_pkg::HUM_MIN;
        end else if (i_humidity > dpt_pkg::HUM_FULL) begin
            n0_h = dpt_pkg::HUM_FULL;
        end else begin
            n0_h = i_humidity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r0_v   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r0_v   <= accept;
        end
        r0_t <= i_temperature;
        r0_h <= n0_h;
    end

    // log2 of the humidity, with the temperature riding along.
    logic          lg_v;
    logic [LW-1:0] lg_l2;
    logic [TW-1:0] lg_t;

    dpt_log2 #(.SW(TW)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_v),
        .i_x     (r0_h),
        .i_side  (r0_t),
        .o_valid (lg_v),
        .o_l2    (lg_l2),
        .o_side  (lg_t)
    );

    // Stage D: distance from the full-scale log; ln(a) - ln(b) scales log2 by ln 2.
    logic                 r1_v;
    logic [LW-1:0]        r1_diff;
    logic signed [TW-1:0] r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= lg_v;
        end
        r1_diff <= (lg_l2 > L2_FULL) ? '0 : L2_FULL - lg_l2;
        r1_t    <= $signed(lg_t);
    end

    // Stage P: split multiply by ln 2, temperature products for term1.
    logic                 r2_v;
    logic [PLW+29:0]      r2_plo;
    logic [PHW+29:0]      r2_phi;
    logic                 r2_tneg;
    logic [TMW-1:0]       r2_tm;
    logic [DW1-1:0]       r2_den1;
    logic [TW-1:0]        n2_tmag;
    logic signed [TW+1:0] n2_tsum;

    assign n2_tmag = r1_t[TW-1] ? TW'(-r1_t) : TW'(r1_t);
    assign n2_tsum = (TW+2)'($signed({1'b0, dpt_pkg::B_COEF})) + (TW+2)'(r1_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_plo  <= (PLW+30)'(r1_diff[PLW-1:0]) * (PLW+30)'(dpt_pkg::LN2_Q30);
        r2_phi  <= (PHW+30)'(r1_diff[LW-1:PLW]) * (PHW+30)'(dpt_pkg::LN2_Q30);
        r2_tneg <= r1_t[TW-1];
        r2_tm   <= TMW'(n2_tmag) * TMW'(dpt_pkg::K_COEF);
        r2_den1 <= DW1'(n2_tsum[15:0]) * DW1'(dpt_pkg::PCT_SCALE);
    end

    // Stage S: join the partial products, build the rounded term1 numerator.
    logic            r3_v;
    logic [DLW-1:0]  r3_d;
    logic [NW1-1:0]  r3_num1;
    logic [DW1-1:0]  r3_den1;
    logic            r3_tneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_d    <= DLW'(r2_plo) + (DLW'(r2_phi) << PLW);
        r3_num1 <= (NW1'(r2_tm) << FRAC_BITS) + NW1'(r2_den1 >> 1);
        r3_den1 <= r2_den1;
        r3_tneg <= r2_tneg;
    end

    // Stage R: round the log term to nearest at FRAC_BITS fraction bits.
    logic            r4_v;
    logic [T2W-1:0]  r4_t2;
    logic [NW1-1:0]  r4_num1;
    logic [DW1-1:0]  r4_den1;
    logic            r4_tneg;
    logic [DLW-1:0]  n4_d;

    assign n4_d = (r3_d + RND_T2) >> (60 - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_t2   <= n4_d[T2W-1:0];
        r4_num1 <= r3_num1;
        r4_den1 <= r3_den1;
        r4_tneg <= r3_tneg;
    end

    // term1 = 17.27*T/(237.7+T), magnitude divided, sign carried alongside.
    logic            d1_v;
    logic [NW1-1:0]  d1_q;
    logic [T2W:0]    d1_side;

    dpt_div #(.NW(NW1), .DW(DW1), .SW(T2W+1)) u_div_t1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_num1),
        .i_den   (r4_den1),
        .i_side  ({r4_tneg, r4_t2}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_side)
    );

    // Stage A: alpha and the divisor 17.27 - alpha.
    logic               r5_v;
    logic               r5_aneg;
    logic [AW-1:0]      r5_amag;
    logic [AW-1:0]      r5_den;
    logic signed [AW:0] n5_t1;
    logic signed [AW:0] n5_alpha;
    logic signed [AW:0] n5_nalpha;
    logic signed [AW:0] n5_den;

    always_comb begin
        n5_t1     = $signed({1'b0, d1_q[AW-1:0]});
        if (d1_side[T2W]) begin
            n5_t1 = -n5_t1;
        end
        n5_alpha  = n5_t1 - $signed({{(AW+1-T2W){1'b0}}, d1_side[T2W-1:0]});
        n5_nalpha = -n5_alpha;
        n5_den    = $signed((AW+1)'(C_DEN)) - n5_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= d1_v;
        end
        r5_aneg <= n5_alpha[AW];
        r5_amag <= n5_alpha[AW] ? n5_nalpha[AW-1:0] : n5_alpha[AW-1:0];
        r5_den  <= (n5_den <= 0) ? AW'(1) : n5_den[AW-1:0];
    end

    // Stage B: 237.7 * |alpha| in hundredths.
    logic            r6_v;
    logic [PW2-1:0]  r6_prod;
    logic [AW-1:0]   r6_den;
    logic            r6_aneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_prod <= PW2'(r5_amag) * PW2'(dpt_pkg::B_COEF);
        r6_den  <= r5_den;
        r6_aneg <= r5_aneg;
    end

    // Stage C: add half the divisor so the quotient rounds to nearest.
    logic            r7_v;
    logic [NW2-1:0]  r7_num;
    logic [AW-1:0]   r7_den;
    logic            r7_aneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_num  <= NW2'(r6_prod) + NW2'(r6_den >> 1);
        r7_den  <= r6_den;
        r7_aneg <= r6_aneg;
    end

    logic            d2_v;
    logic [NW2-1:0]  d2_q;
    logic            d2_neg;

    dpt_div #(.NW(NW2), .DW(AW), .SW(1)) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_aneg),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_neg)
    );

    // Final stage: apply the sign and clip to the output range.
    logic                               r_strobe;
    logic signed [dpt_pkg::DEW_W-1:0]   r_dew;
    logic                               r_sat;
    logic signed [dpt_pkg::DEW_W-1:0]   n_dew;
    logic                               n_sat;

    always_comb begin
        n_sat = 1'b0;
        if (d2_neg) begin
            if (d2_q > NW2'(dpt_pkg::DEW_LOW_MAG)) begin
                n_dew = dpt_pkg::DEW_LOW;
                n_sat = 1'b1;
            end else begin
                n_dew = -$signed(d2_q[dpt_pkg::DEW_W-1:0]);
            end
        end else begin
            if (d2_q > NW2'(dpt_pkg::DEW_HIGH)) begin
                n_dew = $signed(dpt_pkg::DEW_HIGH);
                n_sat = 1'b1;
            end else begin
                n_dew = $signed(d2_q[dpt_pkg::DEW_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= d2_v;
        end
        r_dew <= n_dew;
        r_sat <= n_sat;
    end

    assign o_strobe    = r_strobe;
    assign o_dew       = r_dew;
    assign o_saturated = r_sat;

    // A clipped result sits exactly on one of the two range limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |->
            (o_dew == dpt_pkg::DEW_LOW || o_dew == $signed(dpt_pkg::DEW_HIGH)))
        else $error("saturated result not at a range limit");

    // Every delivered dew point lies inside the output range.
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_dew >= dpt_pkg::DEW_LOW &&
                      o_dew <= $signed(dpt_pkg::DEW_HIGH)))
        else $error("dew point outside output range");

    // Reset empties the pipeline and holds off new words.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && busy))
        else $error("reset did not clear strobe and raise busy");
endmodule
`default_nettype wire
